/* design/nbc_pkg.sv */
// Package for the naive Bayes classifier: sizes, command codes, register indexes.
// Used by nbc_div and naive_bayes_classifier.
package nbc_pkg;
  localparam int unsigned MaxClasses  = 16;
  localparam int unsigned MaxFeatures = 8;
  localparam int unsigned MaxValues   = 16;
  localparam int unsigned CountW      = 16;
  localparam int unsigned ScoreW      = 17;
  localparam logic [16:0] OneQ16      = 17'h10000;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  localparam logic [3:0] FeatureCountRst = 4'd6;
  localparam logic [4:0] ClassCountRst   = 5'd4;

  typedef enum logic [1:0] {
    CmdClear    = 2'd0,
    CmdTrain    = 2'd1,
    CmdClassify = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  localparam logic [0:0] RegFeatureCount = 1'd0;
  localparam logic [0:0] RegClassCount   = 1'd1;
endpackage

/* design/naive_bayes_classifier.sv */
// Categorical naive Bayes classifier: saturating counts in one RAM, argmax scoring.
// Train increments each feature's count; classify runs a divide for each class's prior
// and for each valid feature value, keeping the best score; clear sweeps the RAM.
// One item at a time; the next item is taken the cycle after the result leaves.
// Reset restores totals and config, then sweeps the count RAM to zero with the input
// stalled. Uses nbc_pkg, nbc_ram and nbc_div.
module naive_bayes_classifier #(
  parameter int unsigned MaxClasses  = nbc_pkg::MaxClasses,
  parameter int unsigned MaxFeatures = nbc_pkg::MaxFeatures,
  parameter int unsigned MaxValues   = nbc_pkg::MaxValues
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  class_label_i,
  input  logic [3:0]  feature_0_i,
  input  logic [3:0]  feature_1_i,
  input  logic [3:0]  feature_2_i,
  input  logic [3:0]  feature_3_i,
  input  logic [3:0]  feature_4_i,
  input  logic [3:0]  feature_5_i,
  input  logic [3:0]  feature_6_i,
  input  logic [3:0]  feature_7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  predicted_class_o,
  output logic [16:0] best_score_o,
  output logic        is_prediction_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  localparam int unsigned CW    = (MaxClasses > 1) ? $clog2(MaxClasses) : 1;
  localparam int unsigned FW    = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned VW    = $clog2(MaxValues);
  localparam int unsigned AW    = FW + CW + VW;
  localparam int unsigned Depth = 1 << AW;

  typedef enum logic [11:0] {
    StInit  = 12'b000000000001,
    StSweep = 12'b000000000010,
    StIdle  = 12'b000000000100,
    StTRd   = 12'b000000001000,
    StTWr   = 12'b000000010000,
    StCPri  = 12'b000000100000,
    StCPw   = 12'b000001000000,
    StCRd   = 12'b000010000000,
    StCLd   = 12'b000100000000,
    StCDiv  = 12'b001000000000,
    StCNext = 12'b010000000000,
    StOut   = 12'b100000000000
  } state_e;

  state_e st_q, st_d;
  logic [AW-1:0] sw_q, sw_d;
  logic [3:0] fc_q;
  logic [4:0] cc_q;
  logic [15:0] ct_q [MaxClasses];
  logic [15:0] st_tot_q;
  logic [1:0] cmd_q;
  logic [3:0] lab_q;
  logic [3:0] val_q [8];
  logic [3:0] fi_q, fi_d;
  logic [6:0] ci_q, ci_d;
  logic [16:0] score_q, score_d;
  logic [16:0] best_q, best_d;
  logic [3:0] bcls_q, bcls_d;
  logic       ov_q;
  logic [3:0] opc_q;
  logic [16:0] obs_q;
  logic       oip_q;

  logic [3:0] nf;
  logic [6:0] nc;
  logic       ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0] ram_wd, ram_rd;
  logic       div_start, div_done;
  logic [15:0] div_num, div_den;
  logic [16:0] div_q;
  logic [3:0] cur_val;
  logic       val_ok;
  logic       lab_ok;
  logic [CW-1:0] cur_cls;
  logic [15:0] ct_cur;
  logic [33:0] prod;
  logic       accept;

  assign nf = (fc_q > 4'(MaxFeatures)) ? 4'(MaxFeatures) : fc_q;
  assign nc = ({2'd0, cc_q} > 7'(MaxClasses)) ? 7'(MaxClasses) : {2'd0, cc_q};
  assign cur_val = val_q[fi_q[2:0]];
  assign val_ok = ({3'd0, cur_val} < 7'(MaxValues));
  assign lab_ok = ({3'd0, lab_q} < 7'(MaxClasses));
  assign cur_cls = (st_q inside {StTRd, StTWr}) ? CW'(lab_q) : CW'(ci_q);
  assign ct_cur = ct_q[CW'(ci_q)];
  assign ram_addr = (st_q inside {StInit, StSweep}) ? sw_q :
                    {FW'(fi_q), cur_cls, VW'(cur_val)};
  assign prod = 34'(score_q) * 34'(div_q);
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle) || ov_q;

  nbc_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  nbc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q)
  );

  always_comb begin
    st_d = st_q; sw_d = sw_q; fi_d = fi_q; ci_d = ci_q;
    score_d = score_q; best_d = best_q; bcls_d = bcls_q;
    ram_we = 1'b0; ram_wd = '0;
    div_start = 1'b0; div_num = ct_cur; div_den = st_tot_q;
    case (st_q)
      StInit: begin
        ram_we = 1'b1;
        sw_d = sw_q + AW'(1);
        if (&sw_q) st_d = StIdle;
      end
      StSweep: begin
        ram_we = 1'b1;
        sw_d = sw_q + AW'(1);
        if (&sw_q) st_d = StOut;
      end
      StIdle: begin
        if (accept) begin
          fi_d = '0; ci_d = '0; best_d = '0; bcls_d = '0; sw_d = '0;
          case (command_i)
            nbc_pkg::CmdClear: st_d = StSweep;
            nbc_pkg::CmdTrain: st_d = StTRd;
            nbc_pkg::CmdClassify: st_d = StCPri;
            default: st_d = StOut;
          endcase
        end
      end
      StTRd: begin
        if (!lab_ok || fi_q >= nf) st_d = StOut;
        else if (!val_ok) fi_d = fi_q + 4'd1;
        else st_d = StTWr;
      end
      StTWr: begin
        ram_we = 1'b1;
        ram_wd = (ram_rd == nbc_pkg::CountMax) ? ram_rd : ram_rd + 16'd1;
        fi_d = fi_q + 4'd1;
        st_d = StTRd;
      end
      StCPri: begin
        if (ci_q >= nc) st_d = StOut;
        else begin
          div_start = 1'b1;
          fi_d = '0;
          st_d = StCPw;
        end
      end
      StCPw: begin
        if (div_done) begin
          score_d = div_q;
          st_d = StCRd;
        end
      end
      StCRd: begin
        if (fi_q >= nf) st_d = StCNext;
        else st_d = StCLd;
      end
      StCLd: begin
        if (val_ok) begin
          div_start = 1'b1;
          div_num = ram_rd;
          div_den = ct_cur;
          st_d = StCDiv;
        end else begin
          score_d = '0;
          fi_d = fi_q + 4'd1;
          st_d = StCRd;
        end
      end
      StCDiv: begin
        if (div_done) begin
          score_d = 17'(prod >> 16);
          fi_d = fi_q + 4'd1;
          st_d = StCRd;
        end
      end
      StCNext: begin
        if (ci_q == '0 || score_q > best_q) begin
          best_d = score_q;
          bcls_d = ci_q[3:0];
        end
        ci_d = ci_q + 7'd1;
        st_d = StCPri;
      end
      StOut: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; sw_q <= '0;
      fc_q <= nbc_pkg::FeatureCountRst; cc_q <= nbc_pkg::ClassCountRst;
      ov_q <= 1'b0; st_tot_q <= '0;
      for (int i = 0; i < MaxClasses; i++) ct_q[i] <= '0;
    end else begin
      st_q <= st_d;
      sw_q <= sw_d;
      if (cfg_we_i) begin
        if (cfg_index_i == nbc_pkg::RegFeatureCount) fc_q <= cfg_data_i[3:0];
        if (cfg_index_i == nbc_pkg::RegClassCount) cc_q <= cfg_data_i;
      end
      if (st_q == StOut) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (accept && command_i == nbc_pkg::CmdClear) begin
        st_tot_q <= '0;
        for (int i = 0; i < MaxClasses; i++) ct_q[i] <= '0;
      end
      if (st_q == StTRd && lab_ok && fi_q >= nf) begin
        if (ct_q[cur_cls] != nbc_pkg::CountMax) ct_q[cur_cls] <= ct_q[cur_cls] + 16'd1;
        if (st_tot_q != nbc_pkg::CountMax) st_tot_q <= st_tot_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fi_q <= fi_d; ci_q <= ci_d;
    score_q <= score_d; best_q <= best_d; bcls_q <= bcls_d;
    if (accept) begin
      cmd_q <= command_i; lab_q <= class_label_i;
      val_q[0] <= feature_0_i; val_q[1] <= feature_1_i;
      val_q[2] <= feature_2_i; val_q[3] <= feature_3_i;
      val_q[4] <= feature_4_i; val_q[5] <= feature_5_i;
      val_q[6] <= feature_6_i; val_q[7] <= feature_7_i;
    end
    if (st_q == StOut) begin
      oip_q <= (cmd_q == nbc_pkg::CmdClassify);
      opc_q <= (cmd_q == nbc_pkg::CmdClassify) ? bcls_q : 4'd0;
      obs_q <= (cmd_q == nbc_pkg::CmdClassify) ? best_q : 17'd0;
    end
  end

  assign out_valid_o = ov_q;
  assign predicted_class_o = opc_q;
  assign best_score_o = obs_q;
  assign is_prediction_o = oip_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StInit || st_q == StSweep) |-> in_stall_o) else $error("item taken during sweep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (st_q == StIdle)) else $error("result pending while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable({predicted_class_o, best_score_o, is_prediction_o})))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_prediction_o) |-> (best_score_o == 17'd0 && predicted_class_o == 4'd0))
    else $error("nonzero result on non-classify item");
endmodule

/* design/nbc_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module nbc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* design/nbc_div.sv */
// Restoring divider: floor(num * 65536 / den), capped at 65536, 0 for den 0.
// One quotient bit per cycle. Uses nbc_pkg.
module nbc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [16:0] rem_q, rem_d;
  logic [31:0] shf_q, shf_d;
  logic [15:0] den_q, den_d;
  logic [32:0] quo_q, quo_d;
  logic [16:0] trial;
  logic        done_q, done_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shf_d  = shf_q;
    den_d  = den_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], shf_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      shf_d  = {num_i, 16'd0};
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      shf_d = {shf_q[30:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = (den_q == 16'd0) ? 17'd0 :
                  (quo_q[32:16] != 17'd0 && quo_q > {16'd0, nbc_pkg::OneQ16}) ?
                  nbc_pkg::OneQ16 : quo_q[16:0];
endmodule

/* verif/naive_bayes_classifier_tb.sv */
// Testbench for naive_bayes_classifier: directed and random items, with a
// local count model predicting each result. Depends on nbc_pkg and the design files.
module naive_bayes_classifier_tb;
  localparam int unsigned CycleLimit = 40_000_000;
  localparam int unsigned ExpDepth   = 4;

  typedef struct {
    nbc_pkg::cmd_e cmd;
    logic [3:0]    label;
    logic [3:0]    feat [nbc_pkg::MaxFeatures];
  } sample_t;

  typedef struct {
    logic [3:0]  cls;
    logic [16:0] score;
    logic        is_pred;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [3:0]  class_label_i = '0;
  logic [3:0]  feature_i [nbc_pkg::MaxFeatures];
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  predicted_class_o;
  logic [16:0] best_score_o;
  logic        is_prediction_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  logic [15:0] counts_m [nbc_pkg::MaxFeatures][nbc_pkg::MaxClasses][nbc_pkg::MaxValues];
  logic [15:0] class_tot_m [nbc_pkg::MaxClasses];
  logic [15:0] sample_tot_m;
  logic [3:0]  feat_cnt_m;
  logic [4:0]  class_cnt_m;

  answer_t     exp_mem [ExpDepth];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  longint      cycles = 0;

  initial foreach (feature_i[f]) feature_i[f] = '0;

  always #5 clk_i = ~clk_i;

  naive_bayes_classifier i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i, .class_label_i,
    .feature_0_i(feature_i[0]), .feature_1_i(feature_i[1]),
    .feature_2_i(feature_i[2]), .feature_3_i(feature_i[3]),
    .feature_4_i(feature_i[4]), .feature_5_i(feature_i[5]),
    .feature_6_i(feature_i[6]), .feature_7_i(feature_i[7]),
    .out_valid_o, .out_stall_i, .predicted_class_o, .best_score_o, .is_prediction_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  function automatic logic [16:0] q16_ratio(logic [15:0] num, logic [15:0] den);
    logic [63:0] r;
    if (den == 0) return '0;
    r = {32'd0, num, 16'd0} / den;
    return (r > 64'd65536) ? nbc_pkg::OneQ16 : r[16:0];
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == nbc_pkg::CountMax) ? nbc_pkg::CountMax : v + 16'd1;
  endfunction

  function automatic answer_t classify_step(sample_t s);
    answer_t     a;
    int          nf;
    int          nc;
    logic [63:0] score;
    logic [16:0] lik;
    a = '{cls: '0, score: '0, is_pred: 1'b0};
    nf = (feat_cnt_m > nbc_pkg::MaxFeatures) ? nbc_pkg::MaxFeatures : feat_cnt_m;
    nc = (class_cnt_m > nbc_pkg::MaxClasses) ? nbc_pkg::MaxClasses : class_cnt_m;
    case (s.cmd)
      nbc_pkg::CmdClear: begin
        foreach (counts_m[f, c, v]) counts_m[f][c][v] = '0;
        foreach (class_tot_m[c]) class_tot_m[c] = '0;
        sample_tot_m = '0;
      end
      nbc_pkg::CmdTrain: begin
        if (s.label < nbc_pkg::MaxClasses) begin
          for (int f = 0; f < nf; f++) begin
            if (s.feat[f] < nbc_pkg::MaxValues)
              counts_m[f][s.label][s.feat[f]] = sat_inc(counts_m[f][s.label][s.feat[f]]);
          end
          class_tot_m[s.label] = sat_inc(class_tot_m[s.label]);
          sample_tot_m = sat_inc(sample_tot_m);
        end
      end
      nbc_pkg::CmdClassify: begin
        a.is_pred = 1'b1;
        for (int c = 0; c < nc; c++) begin
          score = {47'd0, q16_ratio(class_tot_m[c], sample_tot_m)};
          for (int f = 0; f < nf; f++) begin
            lik = (s.feat[f] < nbc_pkg::MaxValues) ?
                  q16_ratio(counts_m[f][c][s.feat[f]], class_tot_m[c]) : 17'd0;
            score = (score * {47'd0, lik}) >> 16;
          end
          if (c == 0 || score[16:0] > a.score) begin
            a.score = score[16:0];
            a.cls = c[3:0];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("ERROR %0s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("naive_bayes_classifier: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected item", {13'd0, predicted_class_o}, '0);
      end else begin
        e = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (predicted_class_o !== e.cls)
          report_mismatch("predicted_class", {13'd0, predicted_class_o}, {13'd0, e.cls});
        if (best_score_o !== e.score) report_mismatch("best_score", best_score_o, e.score);
        if (is_prediction_o !== e.is_pred)
          report_mismatch("is_prediction", {16'd0, is_prediction_o}, {16'd0, e.is_pred});
      end
    end
  end

  task automatic send_item(sample_t s);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    command_i = s.cmd;
    class_label_i = s.label;
    foreach (feature_i[f]) feature_i[f] = s.feat[f];
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    exp_mem[exp_wr % ExpDepth] = classify_step(s);
    exp_wr++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [4:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == nbc_pkg::RegFeatureCount) feat_cnt_m = val[3:0];
    else class_cnt_m = val;
  endtask

  function automatic sample_t make_sample(nbc_pkg::cmd_e cmd, logic [3:0] label,
                                          logic [3:0] v);
    sample_t s;
    s.cmd = cmd;
    s.label = label;
    foreach (s.feat[f]) s.feat[f] = v;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    r = $urandom_range(99);
    if (r < 2) s.cmd = nbc_pkg::CmdClear;
    else if (r < 57) s.cmd = nbc_pkg::CmdTrain;
    else if (r < 95) s.cmd = nbc_pkg::CmdClassify;
    else s.cmd = nbc_pkg::CmdNone;
    s.label = ($urandom_range(3) == 0) ? 4'($urandom) :
              4'($urandom_range((class_cnt_m == 0) ? 0 : class_cnt_m - 1));
    foreach (s.feat[f])
      s.feat[f] = ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(2));
    return s;
  endfunction

  task automatic test_directed();
    write_cfg(nbc_pkg::RegFeatureCount, 5'd8);
    write_cfg(nbc_pkg::RegClassCount, 5'd16);
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd0));
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd15, 4'd15));
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd0, 4'd0));
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd15, 4'd15));
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd7, 4'd5));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd15));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd0));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd3, 4'd9));
    send_item(make_sample(nbc_pkg::CmdNone, 4'd15, 4'd15));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd5));
    write_cfg(nbc_pkg::RegFeatureCount, 5'd0);
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd2, 4'd1));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd3));
    write_cfg(nbc_pkg::RegClassCount, 5'd0);
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd0));
    write_cfg(nbc_pkg::RegFeatureCount, 5'd15);
    write_cfg(nbc_pkg::RegClassCount, 5'd31);
    send_item(make_sample(nbc_pkg::CmdTrain, 4'd9, 4'd3));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd3));
    write_cfg(nbc_pkg::RegClassCount, 5'd1);
    write_cfg(nbc_pkg::RegFeatureCount, 5'd1);
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd15));
    send_item(make_sample(nbc_pkg::CmdClear, 4'd15, 4'd15));
    send_item(make_sample(nbc_pkg::CmdClassify, 4'd0, 4'd15));
  endtask

  task automatic test_random(int idle, int stall);
    drain();
    idle_pct = idle;
    stall_pct = stall;
    for (int p = 0; p < 4; p++) begin
      write_cfg(nbc_pkg::RegFeatureCount, ($urandom_range(7) == 0) ? 5'($urandom_range(15))
                                                          : 5'($urandom_range(1, 6)));
      write_cfg(nbc_pkg::RegClassCount, ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                        : 5'($urandom_range(1, 5)));
      for (int i = 0; i < 70; i++) send_item(random_sample());
      if (p == 1) drain();
    end
  endtask

  initial begin
    foreach (counts_m[f, c, v]) counts_m[f][c][v] = '0;
    foreach (class_tot_m[c]) class_tot_m[c] = '0;
    sample_tot_m = '0;
    feat_cnt_m = nbc_pkg::FeatureCountRst;
    class_cnt_m = nbc_pkg::ClassCountRst;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    while (in_stall_o) @(negedge clk_i);
    test_directed();
    test_random(0, 0);
    test_random(54, 0);
    test_random(0, 54);
    test_random(19, 19);
    drain();
    if (errors == 0) begin
      $display("naive_bayes_classifier: match");
    end else begin
      $display("naive_bayes_classifier: mismatch");
    end
    $finish;
  end
endmodule

/* files.f */
design/nbc_pkg.sv
design/nbc_ram.sv
design/nbc_div.sv
design/naive_bayes_classifier.sv
verif/naive_bayes_classifier_tb.sv
